### rtl/bqsi_pkg.sv
// Shared types and codes for the byte queue with sorted insert.
`timescale 1ns / 1ps

package bqsi_pkg;

	// Command codes
	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_SORTED = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_PEEK   = 2'd3
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		cmd_t              cmd;
		logic signed [7:0] data_in;
	} item_t;

	typedef struct packed {
		logic signed [7:0] data_out;
		status_t           status;
		logic [6:0]        occupancy;
	} result_t;

endpackage

### rtl/byte_queue_with_sorted_insert.sv
// Circular byte queue with append, sorted insert, remove and peek.
//
//   channel   signals                        transfer
//   item      start, busy, item              start high and busy low
//   result    done, result                   done high, one cycle, no stall
//   config    cfg_valid, cfg_ready, cfg_data cfg_valid and cfg_ready high
//
// Append, full and empty results appear in the cycle after the command,
// with busy low, so a new command may follow at once. A sorted insert into
// an empty queue also completes in the cycle after. Remove and peek pass
// through ST_READ for the registered slot memory read. Sorted insert into a
// non-empty queue walks ST_SORT, shifting each larger entry toward the tail,
// then ST_PLACE if every entry was shifted: the single memory read port and
// one signed comparator handle one entry per cycle. arst_n clears the
// indices, the count and the capacity (to 64 or DEPTH if smaller); slot
// contents are not cleared. A capacity write empties the queue and is held
// off while busy or start is high. The receiver cannot stall results.
`timescale 1ns / 1ps

module byte_queue_with_sorted_insert
	import bqsi_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  item_t      item,
	output logic       done,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [6:0] cfg_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW = (AW > 7) ? AW : 7;
	localparam int NW = IW + 1;
	localparam logic [6:0] CAP_MAX = (DEPTH > 127) ? 7'd127 : 7'(DEPTH);
	localparam logic [6:0] CAP_RST = (CAP_MAX < 7'd64) ? CAP_MAX : 7'd64;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SORT,
		ST_PLACE
	} state_t;

	state_t        state_q;
	logic [6:0]    cap_q;
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [6:0]    count_q;
	logic [6:0]    k_q;
	logic [AW-1:0] src_q;
	logic [AW-1:0] dst_q;
	item_t         item_q;
	logic          done_q;
	result_t       result_q;

	logic          accept;
	logic          is_full;
	logic          is_empty;
	logic          shift_up;
	logic [AW-1:0] tail_dec;
	logic [AW-1:0] src_dec;
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;
	logic [6:0]    cap_new;

	function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] idx, logic [6:0] cap);
		logic [NW-1:0] nxt;
		nxt = NW'(idx) + 1'b1;
		if (nxt == NW'(cap)) begin
			return '0;
		end
		return nxt[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] wrap_dec(logic [AW-1:0] idx, logic [6:0] cap);
		logic [NW-1:0] last;
		last = NW'(cap) - 1'b1;
		if (idx == '0) begin
			return last[AW-1:0];
		end
		return idx - 1'b1;
	endfunction

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE) && !start;
	assign done      = done_q;
	assign result    = result_q;
	assign is_full   = (count_q >= cap_q);
	assign is_empty  = (count_q == '0);
	assign tail_dec  = wrap_dec(tail_q, cap_q);
	assign src_dec   = wrap_dec(src_q, cap_q);
	assign shift_up  = $signed(item_q.data_in) < $signed(mem_rdata);

	// Clamp the written capacity into the usable range
	always_comb begin
		if (cfg_data == '0) begin
			cap_new = 7'd1;
		end else if (cfg_data > CAP_MAX) begin
			cap_new = CAP_MAX;
		end else begin
			cap_new = cfg_data;
		end
	end

	// Drive the slot memory ports
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = item.data_in;
		mem_raddr = head_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !is_full && item.cmd == CMD_APPEND) begin
					mem_we = 1'b1;
				end else if (accept && !is_full && item.cmd == CMD_SORTED) begin
					mem_we    = is_empty;
					mem_raddr = tail_dec;
				end
			end
			ST_SORT: begin
				mem_we    = 1'b1;
				mem_waddr = dst_q;
				mem_wdata = shift_up ? mem_rdata : item_q.data_in;
				mem_raddr = src_dec;
			end
			ST_PLACE: begin
				mem_we    = 1'b1;
				mem_waddr = dst_q;
				mem_wdata = item_q.data_in;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	bqsi_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Sequencer, queue indices and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			cap_q    <= CAP_RST;
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			done_q   <= 1'b0;
			k_q      <= '0;
			src_q    <= '0;
			dst_q    <= '0;
			item_q   <= '0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= item;
						result_q.data_out <= '0;
						result_q.status <= STAT_OK;
						result_q.occupancy <= count_q;
						if (item.cmd == CMD_APPEND || item.cmd == CMD_SORTED) begin
							if (is_full) begin
								result_q.status <= STAT_FULL;
								done_q <= 1'b1;
							end else if (item.cmd == CMD_APPEND || is_empty) begin
								tail_q <= wrap_inc(tail_q, cap_q);
								count_q <= count_q + 7'd1;
								result_q.occupancy <= count_q + 7'd1;
								done_q <= 1'b1;
							end else begin
								// start the walk from the newest entry
								k_q <= count_q;
								dst_q <= tail_q;
								src_q <= tail_dec;
								state_q <= ST_SORT;
							end
						end else begin
							if (is_empty) begin
								result_q.status <= STAT_EMPTY;
								done_q <= 1'b1;
							end else begin
								state_q <= ST_READ;
							end
						end
					end
				end
				ST_READ: begin
					result_q.data_out <= $signed(mem_rdata);
					if (item_q.cmd == CMD_REMOVE) begin
						head_q <= wrap_inc(head_q, cap_q);
						count_q <= count_q - 7'd1;
						result_q.occupancy <= count_q - 7'd1;
					end
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_SORT: begin
					if (shift_up) begin
						// move the larger entry one slot toward the tail
						k_q <= k_q - 7'd1;
						dst_q <= src_q;
						src_q <= src_dec;
						if (k_q == 7'd1) begin
							state_q <= ST_PLACE;
						end
					end else begin
						tail_q <= wrap_inc(tail_q, cap_q);
						count_q <= count_q + 7'd1;
						result_q.occupancy <= count_q + 7'd1;
						done_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_PLACE: begin
					tail_q <= wrap_inc(tail_q, cap_q);
					count_q <= count_q + 7'd1;
					result_q.occupancy <= count_q + 7'd1;
					done_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Capacity write empties the queue
			if (cfg_valid && cfg_ready) begin
				cap_q   <= cap_new;
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
		end
	end

endmodule

### rtl/bqsi_ram.sv
// Slot memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module bqsi_ram #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];

	// Write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
